/* rtl/nbcs_pkg.sv */
// Package for the nested block comment scanner: state and verdict codes,
// character constants and the whitespace test. No dependencies.
package nbcs_pkg;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_SKIP_OK = 3'd1,
        PH_SKIP_NO = 3'd2,
        PH_SLASH   = 3'd3,
        PH_STAR    = 3'd4,
        PH_BODY    = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        BS_LSLASH = 3'd0,
        BS_LSTAR  = 3'd1,
        BS_WS     = 3'd2,
        BS_NONWS  = 3'd3,
        BS_RSTAR  = 3'd4,
        BS_RSLASH = 3'd5
    } t_body;

    typedef enum logic [1:0] {
        V_CONT   = 2'd0,
        V_ACCEPT = 2'd1,
        V_REJECT = 2'd2,
        V_IDLE   = 2'd3
    } t_verdict;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

/* rtl/nbcs_in_if.sv */
// Input request channel of the comment scanner: valid/ready and one character item.
// No dependencies.
interface nbcs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       at_end;
    logic       start_req;
    logic       comment_allowed;
    logic       error_recovery;

    modport source (output valid, ch, at_end, start_req, comment_allowed, error_recovery,
                    input ready);
    modport sink   (input valid, ch, at_end, start_req, comment_allowed, error_recovery,
                    output ready);
endinterface

/* rtl/nbcs_out_if.sv */
// Result channel of the comment scanner: valid/ready and one verdict item.
// Depends on nbcs_pkg.
interface nbcs_out_if;
    logic                 valid;
    logic                 ready;
    nbcs_pkg::t_verdict   verdict;
    logic                 consumed;
    logic                 skipped;

    modport source (output valid, verdict, consumed, skipped, input ready);
    modport sink   (input valid, verdict, consumed, skipped, output ready);
endinterface

/* rtl/nested_block_comment_scanner_core.sv */
// Nested block comment scanner, one lookahead character per request.
// A request passes through the input register, then the result register; the result register
// loads only when it is empty or its result is being taken, so a stalled result holds it back.
// Throughput: one request per cycle while results are taken; the token state machine and depth
// counter update combinationally between the two registers.
// Reset (i_rst_n low, synchronous): both stages empty, phase idle, body state
// whitespace, depth zero.
// Depends on nbcs_pkg, nbcs_in_if, nbcs_out_if.
module nested_block_comment_scanner_core #(
    parameter int MAX_DEPTH = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    nbcs_in_if.sink           i_in,
    nbcs_out_if.source        o_out
);
    import nbcs_pkg::*;

    // Depth counter holds 0..MAX_DEPTH.
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);
    localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(1);

    // Input register stage.
    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_at_end;
    logic       r_start;
    logic       r_allowed;
    logic       r_recov;

    // Result register stage.
    logic       r_out_valid;
    t_verdict   r_verdict;
    logic       r_consumed;
    logic       r_skipped;

    // Token state.
    t_phase               r_phase, n_phase;
    t_body                r_body,  n_body;
    logic [DEPTH_W-1:0]   r_depth, n_depth;

    t_verdict   n_verdict;
    logic       n_consumed;
    logic       n_skipped;

    logic       advance;
    logic       fire;

    // The result register frees up when empty or when its request is taken;
    // the input stage then drains into it, so the input stage can refill.
    assign advance    = !r_out_valid || o_out.ready;
    assign fire       = r_in_valid && advance;
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid    = r_out_valid;
    assign o_out.verdict  = r_verdict;
    assign o_out.consumed = r_consumed;
    assign o_out.skipped  = r_skipped;

    // Input stage: capture a request whenever the stage is free or draining.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_ch      <= i_in.ch;
            r_at_end  <= i_in.at_end;
            r_start   <= i_in.start_req;
            r_allowed <= i_in.comment_allowed;
            r_recov   <= i_in.error_recovery;
        end
    end

    // Result stage: load on fire, drop valid once taken with nothing behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_verdict  <= n_verdict;
            r_consumed <= n_consumed;
            r_skipped  <= n_skipped;
        end
    end

    // State registers advance only with a processed request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_body  <= BS_WS;
            r_depth <= '0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_body  <= n_body;
            r_depth <= n_depth;
        end
    end

    // Next state and verdict for the request in the input stage.
    always_comb begin
        t_phase             ph;
        logic               ws;
        logic               eof;
        logic [DEPTH_W-1:0] dec;

        ws  = is_ws(r_ch);
        eof = r_at_end;
        ph  = r_phase;

        n_phase    = r_phase;
        n_body     = r_body;
        n_depth    = r_depth;
        n_verdict  = V_CONT;
        n_consumed = 1'b0;
        n_skipped  = 1'b0;
        dec        = (r_depth != '0) ? (r_depth - DEPTH_ONE) : r_depth;

        // A start request abandons any open attempt and begins afresh.
        if (r_start) begin
            n_body  = BS_WS;
            n_depth = '0;
            ph      = r_allowed ? PH_SKIP_OK : PH_SKIP_NO;
        end

        if (r_start && r_recov) begin
            // Error recovery: reject straight away.
            n_phase   = PH_IDLE;
            n_verdict = V_REJECT;
        end else begin
            unique case (ph)
                PH_SKIP_OK, PH_SKIP_NO: begin
                    if (!eof && ws) begin
                        // Leading whitespace outside the token.
                        n_phase    = ph;
                        n_consumed = 1'b1;
                        n_skipped  = 1'b1;
                    end else if (ph == PH_SKIP_OK && !eof && r_ch == CH_SLASH) begin
                        n_phase    = PH_SLASH;
                        n_consumed = 1'b1;
                    end else begin
                        n_phase   = PH_IDLE;
                        n_verdict = V_REJECT;
                    end
                end
                PH_SLASH: begin
                    if (!eof && r_ch == CH_STAR) begin
                        n_phase    = PH_STAR;
                        n_consumed = 1'b1;
                    end else begin
                        n_phase   = PH_IDLE;
                        n_verdict = V_REJECT;
                    end
                end
                PH_STAR: begin
                    if (eof) begin
                        // End of input right after the opener accepts.
                        n_phase   = PH_IDLE;
                        n_verdict = V_ACCEPT;
                    end else if (ws) begin
                        n_phase    = PH_BODY;
                        n_body     = BS_WS;
                        n_depth    = DEPTH_ONE;
                        n_consumed = 1'b1;
                    end else begin
                        n_phase   = PH_IDLE;
                        n_verdict = V_REJECT;
                    end
                end
                PH_BODY: begin
                    n_phase    = PH_BODY;
                    n_consumed = 1'b1;
                    if (eof) begin
                        // End of input inside the comment accepts.
                        n_phase    = PH_IDLE;
                        n_verdict  = V_ACCEPT;
                        n_consumed = 1'b0;
                    end else begin
                        unique case (r_body)
                            BS_LSLASH: begin
                                n_body = (r_ch == CH_STAR) ? BS_LSTAR :
                                         (ws ? BS_WS : BS_NONWS);
                            end
                            BS_LSTAR: begin
                                if (ws) begin
                                    // Nested opener; saturate at the maximum.
                                    n_body = BS_WS;
                                    if (r_depth < DEPTH_MAX) begin
                                        n_depth = r_depth + DEPTH_ONE;
                                    end
                                end else begin
                                    n_body = BS_NONWS;
                                end
                            end
                            BS_WS: begin
                                if (r_ch == CH_SLASH) begin
                                    n_body = BS_LSLASH;
                                end else if (r_ch == CH_STAR) begin
                                    n_body = BS_RSTAR;
                                end else if (!ws) begin
                                    n_body = BS_NONWS;
                                end
                            end
                            BS_NONWS: begin
                                if (ws) begin
                                    n_body = BS_WS;
                                end
                            end
                            BS_RSTAR: begin
                                n_body = (r_ch == CH_SLASH) ? BS_RSLASH :
                                         (ws ? BS_WS : BS_NONWS);
                            end
                            BS_RSLASH: begin
                                if (ws) begin
                                    // Closer; the outermost one ends the token and
                                    // leaves its whitespace unconsumed.
                                    n_depth = dec;
                                    if (dec == '0) begin
                                        n_phase    = PH_IDLE;
                                        n_verdict  = V_ACCEPT;
                                        n_consumed = 1'b0;
                                    end else begin
                                        n_body = BS_WS;
                                    end
                                end else begin
                                    n_body = BS_NONWS;
                                end
                            end
                            default: begin
                                n_body = BS_WS;
                            end
                        endcase
                    end
                end
                default: begin
                    // No attempt open.
                    n_phase   = PH_IDLE;
                    n_verdict = V_IDLE;
                end
            endcase
        end
    end

endmodule
